@@ rtl/prfb_pkg.sv @@
`default_nettype none

package prfb_pkg;

  // fixed field widths
  localparam int ADDR_W      = 24;
  localparam int COORD_W     = 10;
  localparam int COLOR_W     = 8;
  localparam int MASK_W      = 16;
  localparam int MOD_W       = 16;
  localparam int WCOUNT_W    = 6;
  localparam int PLANE_W     = 3;
  localparam int LINE_W      = 8;
  localparam int PCOUNT_W    = 4;
  localparam int SPAN_W      = 7;
  localparam int YOFF_W      = 22;
  localparam int XWORD_W     = 6;
  localparam int STRIDE_W    = 12;

  // packed stream widths
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 80;

  // parameter defaults
  localparam int MAX_PLANES_DEF = 8;
  localparam int ADDR_BITS_DEF  = 24;

  // register reset values
  localparam logic [LINE_W-1:0]   LINE_BYTES_RESET  = 8'd40;
  localparam logic [PCOUNT_W-1:0] PLANE_COUNT_RESET = 4'd5;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CFG_LINE_BYTES  = 1'b0,
    CFG_PLANE_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT,
    ST_MID
  } step_e;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_SOLID = 1'b1
  } op_kind_e;

  // one classified fill request
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [YOFF_W-1:0]  yoff;
    logic [XWORD_W-1:0] xword;
    logic [MASK_W-1:0]  smask;
    logic [MASK_W-1:0]  emask;
    logic [SPAN_W-1:0]  span;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] height;
  } desc_t;

endpackage

`default_nettype wire

@@ rtl/planar_rect_fill_blit_splitter.sv @@
// Planar rectangle fill splitter: turns one fill request for an interleaved
// planar bitmap into blit command items, plane by plane.
// Input stream s_axis: one request per item. Output stream m_axis: one
// command per item, tlast on the final command of a request, tuser is the
// operation kind (edge merge or solid middle write).
// Per plane up to three commands: left edge, right edge (span of two or more
// words), solid middle (span of three or more words).
// The first command of a request passes front stage one, front stage two,
// the queue write, the load step and the output register before it is offered.
// The command sequencer issues one command per cycle while the receiver takes
// them, after a load step per request. The front keeps taking requests into a
// two-entry queue while the sequencer works.
// Requests of zero width or height produce no commands.
// Reset empties the pipeline and the queue and loads line_bytes = 40 and
// plane_count = 5. A stalled receiver holds the current command in the output
// register; the sequencer, then the queue and finally s_axis_tready stall.
// Configuration is taken through cfg_we_i; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
`default_nettype none

module planar_rect_fill_blit_splitter #(
  parameter int MAX_PLANES = prfb_pkg::MAX_PLANES_DEF,
  parameter int ADDR_BITS  = prfb_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_index_i,
  input  wire logic [prfb_pkg::LINE_W-1:0]       cfg_wdata_i,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // base_address, x_pos, y_pos, width, height, color
  input  wire logic [prfb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // fill_ones, edge_mask, target_address, row_modulo, word_count,
  // row_count, plane_index, zero pad
  output logic [prfb_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // op_kind
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  logic [prfb_pkg::LINE_W-1:0]   line_bytes_q;
  logic [prfb_pkg::PCOUNT_W-1:0] plane_count_q;
  logic [prfb_pkg::PCOUNT_W-1:0] planes;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q  <= prfb_pkg::LINE_BYTES_RESET;
      plane_count_q <= prfb_pkg::PLANE_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (prfb_pkg::cfg_idx_e'(cfg_index_i))
        prfb_pkg::CFG_LINE_BYTES:  line_bytes_q  <= cfg_wdata_i;
        prfb_pkg::CFG_PLANE_COUNT: plane_count_q <= cfg_wdata_i[prfb_pkg::PCOUNT_W-1:0];
        default: line_bytes_q <= line_bytes_q;
      endcase
    end
  end

  // plane count clamped to one .. MAX_PLANES
  always_comb begin
    if (plane_count_q == '0) begin
      planes = 4'd1;
    end else if (plane_count_q > prfb_pkg::PCOUNT_W'(MAX_PLANES)) begin
      planes = prfb_pkg::PCOUNT_W'(MAX_PLANES);
    end else begin
      planes = plane_count_q;
    end
  end

  prfb_pkg::desc_t push_data, head_data;
  logic            push, full, pop, empty;

  prfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .line_bytes_i (line_bytes_q),
    .planes_i     (planes),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  prfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (empty)
  );

  prfb_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_bytes_i (line_bytes_q),
    .planes_i     (planes),
    .desc_i       (head_data),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_kind_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/prfb_front.sv @@
`default_nettype none

module prfb_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [prfb_pkg::IN_DATA_W-1:0]     in_data_i,
  input  wire logic [prfb_pkg::LINE_W-1:0]        line_bytes_i,
  input  wire logic [prfb_pkg::PCOUNT_W-1:0]      planes_i,
  output logic                                    push_o,
  output prfb_pkg::desc_t                         push_data_o,
  input  wire logic                               full_i
);

  // input field unpacking
  logic [prfb_pkg::ADDR_W-1:0]  in_base;
  logic [prfb_pkg::COORD_W-1:0] in_x, in_y, in_w, in_h;
  logic [prfb_pkg::COLOR_W-1:0] in_color;

  assign in_base  = in_data_i[23:0];
  assign in_x     = in_data_i[33:24];
  assign in_y     = in_data_i[43:34];
  assign in_w     = in_data_i[53:44];
  assign in_h     = in_data_i[63:54];
  assign in_color = in_data_i[71:64];

  // stage one: raw request
  logic                         s1_v_q;
  logic [prfb_pkg::ADDR_W-1:0]  s1_base_q;
  logic [prfb_pkg::COORD_W-1:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic [prfb_pkg::COLOR_W-1:0] s1_color_q;

  // stage two: masks, span and row offset part
  logic                           s2_v_q;
  logic [prfb_pkg::ADDR_W-1:0]    s2_base_q;
  logic [17:0]                    s2_ylb_q;
  logic [prfb_pkg::XWORD_W-1:0]   s2_xword_q;
  logic [prfb_pkg::MASK_W-1:0]    s2_smask_q, s2_emask_q;
  logic [prfb_pkg::SPAN_W-1:0]    s2_span_q;
  logic [prfb_pkg::COLOR_W-1:0]   s2_color_q;
  logic [prfb_pkg::COORD_W-1:0]   s2_h_q;

  logic accept, s1_move;

  assign push_o     = s2_v_q && !full_i;
  assign s1_move    = s1_v_q && (!s2_v_q || push_o);
  assign in_ready_o = !s1_v_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  // edge masks and word span
  logic [3:0]                  xo, e;
  logic [10:0]                 span_sum;
  logic [prfb_pkg::SPAN_W-1:0] span;
  logic [prfb_pkg::MASK_W-1:0] smask, emask;

  always_comb begin
    xo       = s1_x_q[3:0];
    e        = 4'(s1_x_q[3:0] + s1_w_q[3:0]);
    span_sum = 11'({7'd0, xo}) + 11'(s1_w_q) + 11'd15;
    span     = prfb_pkg::SPAN_W'(span_sum >> 4);
    emask    = (e == 4'd0) ? 16'hffff : ~(16'hffff >> e);
    smask    = 16'hffff >> xo;
    if (span == 7'd1) begin
      smask = smask & emask;
    end
  end

  // control of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (accept) begin
        // empty rectangles are dropped here
        s1_v_q <= (in_w != '0) && (in_h != '0);
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (push_o) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_base_q  <= in_base;
      s1_x_q     <= in_x;
      s1_y_q     <= in_y;
      s1_w_q     <= in_w;
      s1_h_q     <= in_h;
      s1_color_q <= in_color;
    end
    if (s1_move) begin
      s2_base_q  <= s1_base_q;
      s2_ylb_q   <= 18'(s1_y_q * line_bytes_i);
      s2_xword_q <= s1_x_q[9:4];
      s2_smask_q <= smask;
      s2_emask_q <= emask;
      s2_span_q  <= span;
      s2_color_q <= s1_color_q;
      s2_h_q     <= s1_h_q;
    end
  end

  // row offset finished on the way into the queue
  always_comb begin
    push_data_o.base   = s2_base_q;
    push_data_o.yoff   = prfb_pkg::YOFF_W'(s2_ylb_q * planes_i);
    push_data_o.xword  = s2_xword_q;
    push_data_o.smask  = s2_smask_q;
    push_data_o.emask  = s2_emask_q;
    push_data_o.span   = s2_span_q;
    push_data_o.color  = s2_color_q;
    push_data_o.height = s2_h_q;
  end

endmodule

`default_nettype wire

@@ rtl/prfb_fifo.sv @@
`default_nettype none

module prfb_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  prfb_pkg::desc_t    data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output prfb_pkg::desc_t    data_o,
  output logic               empty_o
);

  localparam int Depth  = prfb_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  prfb_pkg::desc_t   entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  assign full_o  = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

  a_level_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost a written entry");

endmodule

`default_nettype wire

@@ rtl/prfb_back.sv @@
`default_nettype none

module prfb_back #(
  parameter int ADDR_BITS = prfb_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [prfb_pkg::LINE_W-1:0]      line_bytes_i,
  input  wire logic [prfb_pkg::PCOUNT_W-1:0]    planes_i,
  input  prfb_pkg::desc_t                       desc_i,
  input  wire logic                             empty_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [prfb_pkg::OUT_DATA_W-1:0]       out_data_o,
  output logic                                  out_kind_o,
  output logic                                  out_last_o
);

  localparam int AW       = prfb_pkg::ADDR_W;
  localparam int AddrKeep = (ADDR_BITS < AW) ? ADDR_BITS : AW;
  localparam logic [AW-1:0] AddrMask = {AW{1'b1}} >> (AW - AddrKeep);

  prfb_pkg::step_e state_q, state_d;

  // held request
  logic [AW-1:0]                  addr_q;
  logic [prfb_pkg::PLANE_W-1:0]   plane_q;
  logic [prfb_pkg::MASK_W-1:0]    smask_q, emask_q;
  logic [prfb_pkg::SPAN_W-1:0]    span_q;
  logic [prfb_pkg::COLOR_W-1:0]   color_q;
  logic [prfb_pkg::COORD_W-1:0]   height_q;

  // output register
  logic                           out_valid_q;
  logic [prfb_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_kind_q, out_last_q;

  logic emit, plane_end, last_plane;

  assign emit       = (state_q != prfb_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign last_plane = ({1'b0, plane_q} == (planes_i - 4'd1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prfb_pkg::ST_IDLE: begin
        if (!empty_i) state_d = prfb_pkg::ST_LEFT;
      end
      prfb_pkg::ST_LEFT: begin
        if (emit) begin
          if (span_q > 7'd1) state_d = prfb_pkg::ST_RIGHT;
          else state_d = last_plane ? prfb_pkg::ST_IDLE : prfb_pkg::ST_LEFT;
        end
      end
      prfb_pkg::ST_RIGHT: begin
        if (emit) begin
          if (span_q > 7'd2) state_d = prfb_pkg::ST_MID;
          else state_d = last_plane ? prfb_pkg::ST_IDLE : prfb_pkg::ST_LEFT;
        end
      end
      prfb_pkg::ST_MID: begin
        if (emit) state_d = last_plane ? prfb_pkg::ST_IDLE : prfb_pkg::ST_LEFT;
      end
      default: state_d = prfb_pkg::ST_IDLE;
    endcase
  end

  // command fields of the current step
  logic [prfb_pkg::STRIDE_W-1:0] stride;
  logic [prfb_pkg::SPAN_W-1:0]   span_m1, span_m2;
  prfb_pkg::op_kind_e            cmd_kind;
  logic [prfb_pkg::MASK_W-1:0]   cmd_mask;
  logic [AW-1:0]                 cmd_addr, load_addr;
  logic [prfb_pkg::MOD_W-1:0]    cmd_mod;
  logic [prfb_pkg::WCOUNT_W-1:0] cmd_words;

  always_comb begin
    pop_o     = (state_q == prfb_pkg::ST_IDLE) && !empty_i;
    stride    = prfb_pkg::STRIDE_W'(line_bytes_i * planes_i);
    span_m1   = span_q - 7'd1;
    span_m2   = span_q - 7'd2;
    load_addr = desc_i.base + AW'(desc_i.yoff) + AW'({desc_i.xword, 1'b0});
    cmd_kind  = prfb_pkg::OP_EDGE;
    cmd_mask  = smask_q;
    cmd_addr  = addr_q;
    cmd_mod   = 16'(stride) - 16'd2;
    cmd_words = 6'd1;
    plane_end = 1'b0;
    unique case (state_q)
      prfb_pkg::ST_IDLE: begin
        plane_end = 1'b0;
      end
      prfb_pkg::ST_LEFT: begin
        plane_end = (span_q <= 7'd1);
      end
      prfb_pkg::ST_RIGHT: begin
        cmd_mask  = emask_q;
        cmd_addr  = addr_q + AW'({span_m1, 1'b0});
        plane_end = (span_q <= 7'd2);
      end
      prfb_pkg::ST_MID: begin
        cmd_kind  = prfb_pkg::OP_SOLID;
        cmd_mask  = '0;
        cmd_addr  = addr_q + AW'(2);
        cmd_mod   = 16'(stride) - 16'({span_m2, 1'b0});
        cmd_words = span_m2[prfb_pkg::WCOUNT_W-1:0];
        plane_end = 1'b1;
      end
      default: plane_end = 1'b0;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prfb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request hold, plane walk and command register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q   <= load_addr;
      plane_q  <= '0;
      smask_q  <= desc_i.smask;
      emask_q  <= desc_i.emask;
      span_q   <= desc_i.span;
      color_q  <= desc_i.color;
      height_q <= desc_i.height;
    end else if (emit && plane_end) begin
      addr_q  <= addr_q + AW'(line_bytes_i);
      plane_q <= plane_q + 1'b1;
    end
    if (emit) begin
      out_data_q <= {4'd0, plane_q, height_q, cmd_words, cmd_mod,
                     cmd_addr & AddrMask, cmd_mask, color_q[plane_q]};
      out_kind_q <= cmd_kind;
      out_last_q <= plane_end && last_plane;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && plane_end && last_plane) |=> (state_q == prfb_pkg::ST_IDLE))
    else $error("sequencer kept running after the final command");

  a_plane_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != prfb_pkg::ST_IDLE) |-> ({1'b0, plane_q} < planes_i))
    else $error("plane walk passed the plane count");

  a_step_needs_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == prfb_pkg::ST_RIGHT) |-> (span_q > 7'd1)) and
    ((state_q == prfb_pkg::ST_MID) |-> (span_q > 7'd2)))
    else $error("edge or middle step without the span for it");

endmodule

`default_nettype wire
